// ===== rtl/irpdt_pkg.sv =====
// Package for the IR pulse-distance transceiver: sizes, configuration layout,
// register indexes and the result record, in a package shared by all rtl files.
// No dependencies.
`default_nettype none

package irpdt_pkg;

  // Code length in bits and the ceiling of the quiet (high) run counter.
  localparam int CODE_BITS      = 16;
  localparam int HIGH_RUN_LIMIT = 10000;

  localparam int HIGH_RUN_W = $clog2(HIGH_RUN_LIMIT + 1);
  localparam int BIT_CNT_W  = $clog2(CODE_BITS + 1);
  localparam int BIT_IDX_W  = $clog2(CODE_BITS);

  localparam int REG_W    = 8;
  localparam int REG_IDX_W = 3;
  localparam int CODE_W   = 16;
  localparam int DIR_W    = 8;
  localparam int LED_W    = 4;
  localparam int LOW_RUN_W = 8;

  localparam logic [LOW_RUN_W-1:0] LOW_RUN_MAX = '1;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_SHORT_LOW_MIN    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SHORT_LOW_MAX    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LONG_LOW_MIN     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LONG_LOW_MAX     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SEND_SHORT_TICKS = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SEND_LONG_TICKS  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SEND_LEAD_TICKS  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_VOICE_DIRECTION  = 3'd7;

  typedef struct packed {
    logic [REG_W-1:0] short_low_min;
    logic [REG_W-1:0] short_low_max;
    logic [REG_W-1:0] long_low_min;
    logic [REG_W-1:0] long_low_max;
    logic [REG_W-1:0] send_short_ticks;
    logic [REG_W-1:0] send_long_ticks;
    logic [REG_W-1:0] send_lead_ticks;
    logic [REG_W-1:0] voice_direction;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    short_low_min:    8'd2,
    short_low_max:    8'd5,
    long_low_min:     8'd10,
    long_low_max:     8'd14,
    send_short_ticks: 8'd4,
    send_long_ticks:  8'd12,
    send_lead_ticks:  8'd50,
    voice_direction:  8'd1
  };

  // Receiver outcome of one tick.
  typedef struct packed {
    logic                  code_valid;
    logic [CODE_W-1:0]     received_code;
    logic [HIGH_RUN_W-1:0] quiet_level;
  } rx_status_t;

  // Transmitter outcome of one transfer.
  typedef struct packed {
    logic             send_accepted;
    logic [LED_W-1:0] led_lines;
    logic             carrier_run;
    logic             busy_sending;
  } tx_status_t;

  typedef struct packed {
    rx_status_t rx;
    tx_status_t tx;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/irpdt_rx.sv =====
// Receiver: times low and high runs of the sampled level and decodes bits.
// Depends on irpdt_pkg.
`default_nettype none

module irpdt_rx (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                tick,
  input  wire logic                rx_level,
  input  wire irpdt_pkg::cfg_t     cfg,
  output      irpdt_pkg::rx_status_t status
);
  import irpdt_pkg::*;

  logic                  was_low, was_low_next;
  logic [LOW_RUN_W-1:0]  low_run, low_run_next;
  logic [HIGH_RUN_W-1:0] high_run, high_run_next;
  logic [BIT_CNT_W-1:0]  bit_count, bit_count_next;
  logic [CODE_BITS-1:0]  shift, shift_next;
  logic                  is_zero, is_one, got;
  logic [BIT_CNT_W-1:0]  count_inc;

  assign is_zero = (low_run >= cfg.short_low_min) && (low_run <= cfg.short_low_max);
  assign is_one  = (low_run >= cfg.long_low_min) && (low_run <= cfg.long_low_max);
  assign count_inc = bit_count + BIT_CNT_W'(1);

  always_comb begin
    was_low_next   = was_low;
    low_run_next   = low_run;
    high_run_next  = high_run;
    bit_count_next = bit_count;
    shift_next     = shift;
    got            = 1'b0;
    if (rx_level) begin
      if (was_low) begin
        // Rising edge: classify the low period that just ended.
        if (is_zero || is_one) begin
          if (high_run > HIGH_RUN_W'(cfg.long_low_max)) begin
            shift_next     = CODE_BITS'(is_one && !is_zero);
            bit_count_next = BIT_CNT_W'(1);
          end else if (bit_count != '0) begin
            shift_next     = {shift[CODE_BITS-2:0], is_one && !is_zero};
            bit_count_next = count_inc;
            if (count_inc >= BIT_CNT_W'(CODE_BITS)) begin
              got            = 1'b1;
              bit_count_next = '0;
            end
          end
        end else begin
          bit_count_next = '0;
        end
        high_run_next = HIGH_RUN_W'(1);
        was_low_next  = 1'b0;
      end else if (high_run < HIGH_RUN_W'(HIGH_RUN_LIMIT)) begin
        high_run_next = high_run + HIGH_RUN_W'(1);
      end
    end else begin
      if (was_low) begin
        if (low_run != LOW_RUN_MAX) begin
          low_run_next = low_run + LOW_RUN_W'(1);
        end
      end else begin
        low_run_next = LOW_RUN_W'(1);
        was_low_next = 1'b1;
      end
    end
  end

  always_comb begin
    status.code_valid    = tick && got;
    status.received_code = (tick && got) ? CODE_W'(shift_next) : '0;
    if (tick) begin
      status.quiet_level = was_low_next ? '0 : high_run_next;
    end else begin
      status.quiet_level = was_low ? '0 : high_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_low   <= 1'b0;
      low_run   <= '0;
      high_run  <= '0;
      bit_count <= '0;
      shift     <= '0;
    end else if (tick) begin
      was_low   <= was_low_next;
      low_run   <= low_run_next;
      high_run  <= high_run_next;
      bit_count <= bit_count_next;
      shift     <= shift_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/irpdt_tx.sv =====
// Transmitter: takes send requests and sequences lead, on and off periods.
// Depends on irpdt_pkg.
`default_nettype none

module irpdt_tx (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      tick,
  input  wire logic                      request,
  input  wire logic [irpdt_pkg::DIR_W-1:0]  send_direction,
  input  wire logic [irpdt_pkg::CODE_W-1:0] send_code,
  input  wire irpdt_pkg::cfg_t           cfg,
  output      irpdt_pkg::tx_status_t     status
);
  import irpdt_pkg::*;

  logic                 active, active_next;
  logic                 lead, lead_next;
  logic [CODE_BITS-1:0] word, word_next;
  logic [DIR_W-1:0]     dir, dir_next;
  logic [BIT_CNT_W-1:0] bits_left, bits_left_next;
  logic [REG_W-1:0]     wait_cnt, wait_cnt_next;
  logic [REG_W-1:0]     second_wait, second_wait_next;
  logic [LED_W-1:0]     line, line_next;
  logic                 carrier, carrier_next;
  logic                 drive_on, drive_off, voice, cur_bit;
  logic                 accepted;
  logic [BIT_CNT_W-1:0] bits_dec;

  assign voice    = (dir == cfg.voice_direction);
  assign bits_dec = bits_left - BIT_CNT_W'(1);
  assign cur_bit  = word[bits_dec[BIT_IDX_W-1:0]];

  always_comb begin
    active_next      = active;
    lead_next        = lead;
    word_next        = word;
    dir_next         = dir;
    bits_left_next   = bits_left;
    wait_cnt_next    = wait_cnt;
    second_wait_next = second_wait;
    drive_on         = 1'b0;
    drive_off        = 1'b0;
    accepted         = 1'b0;
    if (request) begin
      if (!active) begin
        dir_next    = send_direction;
        word_next   = CODE_BITS'(send_code);
        lead_next   = 1'b1;
        active_next = 1'b1;
        accepted    = 1'b1;
      end
    end else if (tick && active) begin
      if (lead) begin
        drive_off        = 1'b1;
        wait_cnt_next    = cfg.send_lead_ticks;
        second_wait_next = '0;
        bits_left_next   = BIT_CNT_W'(CODE_BITS);
        lead_next        = 1'b0;
      end else if (wait_cnt != '0) begin
        wait_cnt_next = wait_cnt - REG_W'(1);
      end else if (second_wait != '0) begin
        drive_off        = 1'b1;
        wait_cnt_next    = second_wait;
        second_wait_next = '0;
      end else if (bits_left != '0) begin
        drive_on       = 1'b1;
        bits_left_next = bits_dec;
        // A one bit is a long on period then a short off period.
        if (cur_bit) begin
          wait_cnt_next    = cfg.send_long_ticks;
          second_wait_next = cfg.send_short_ticks;
        end else begin
          wait_cnt_next    = cfg.send_short_ticks;
          second_wait_next = cfg.send_long_ticks;
        end
      end else begin
        drive_off   = 1'b1;
        active_next = 1'b0;
      end
    end
  end

  // Line and carrier update; the voice path never touches the carrier.
  always_comb begin
    line_next    = line;
    carrier_next = carrier;
    if (drive_on) begin
      if (voice) begin
        line_next = line | LED_W'(1);
      end else begin
        line_next    = line | dir[5:2];
        carrier_next = 1'b1;
      end
    end else if (drive_off) begin
      line_next = '0;
      if (!voice) begin
        carrier_next = 1'b0;
      end
    end
  end

  assign status.send_accepted = accepted;
  assign status.led_lines     = line_next;
  assign status.carrier_run   = carrier_next;
  assign status.busy_sending  = active_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      lead        <= 1'b0;
      word        <= '0;
      dir         <= '0;
      bits_left   <= '0;
      wait_cnt    <= '0;
      second_wait <= '0;
      line        <= '0;
      carrier     <= 1'b0;
    end else if (tick || request) begin
      active      <= active_next;
      lead        <= lead_next;
      word        <= word_next;
      dir         <= dir_next;
      bits_left   <= bits_left_next;
      wait_cnt    <= wait_cnt_next;
      second_wait <= second_wait_next;
      line        <= line_next;
      carrier     <= carrier_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ir_pulse_distance_transceiver_core.sv =====
// Top level of the IR pulse-distance transceiver core.
// Depends on irpdt_pkg, irpdt_rx and irpdt_tx.
`default_nettype none

// Each input transfer is either a sampling tick (op = 0) carrying the level
// of the IR receiver pin, or a send request (op = 1) carrying a direction and
// a 16-bit code. Every input transfer yields exactly one result transfer that
// shows the state right after that item: whether a request was taken, a code
// that completed on this tick, the LED lines, the carrier enable, the busy
// flag and the current quiet (high) run length. On a tick the receiver runs
// first and the transmitter then advances by one tick. A send request is only
// taken while the transmitter is idle; otherwise it is dropped with
// send_accepted low. While in_stall is low the block takes one item per clock
// cycle: each item is handled by one pass of counter and compare logic between
// the input and a result register, and a two-entry output stage (result
// register plus skid register) keeps input accepted while one result waits
// under out_stall. Configuration registers are written through
// cfg_we/cfg_index/cfg_data and should only be changed while no result is
// outstanding.
module ir_pulse_distance_transceiver_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Configuration write port.
  input  wire logic                             cfg_we,
  input  wire logic [irpdt_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [irpdt_pkg::REG_W-1:0]      cfg_data,
  // Input channel.
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic                             op,
  input  wire logic                             rx_level,
  input  wire logic [irpdt_pkg::DIR_W-1:0]      send_direction,
  input  wire logic [irpdt_pkg::CODE_W-1:0]     send_code,
  // Result channel.
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic                             send_accepted,
  output      logic                             code_valid,
  output      logic [irpdt_pkg::CODE_W-1:0]     received_code,
  output      logic [irpdt_pkg::LED_W-1:0]      led_lines,
  output      logic                             carrier_run,
  output      logic                             busy_sending,
  output      logic [irpdt_pkg::HIGH_RUN_W-1:0] quiet_level
);
  import irpdt_pkg::*;

  cfg_t       cfg;
  logic       accept, tick, request;
  rx_status_t rx_status;
  tx_status_t tx_status;
  result_t    result, out_res, skid_res;
  logic       skid_valid;

  // The input side only stalls when the skid register is occupied.
  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign tick     = accept && !op;
  assign request  = accept && op;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHORT_LOW_MIN:    cfg.short_low_min    <= cfg_data;
        REG_SHORT_LOW_MAX:    cfg.short_low_max    <= cfg_data;
        REG_LONG_LOW_MIN:     cfg.long_low_min     <= cfg_data;
        REG_LONG_LOW_MAX:     cfg.long_low_max     <= cfg_data;
        REG_SEND_SHORT_TICKS: cfg.send_short_ticks <= cfg_data;
        REG_SEND_LONG_TICKS:  cfg.send_long_ticks  <= cfg_data;
        REG_SEND_LEAD_TICKS:  cfg.send_lead_ticks  <= cfg_data;
        REG_VOICE_DIRECTION:  cfg.voice_direction  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  irpdt_rx u_rx (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick),
    .rx_level (rx_level),
    .cfg      (cfg),
    .status   (rx_status)
  );

  irpdt_tx u_tx (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick),
    .request        (request),
    .send_direction (send_direction),
    .send_code      (send_code),
    .cfg            (cfg),
    .status         (tx_status)
  );

  assign result.rx = rx_status;
  assign result.tx = tx_status;

  // Output stage: the result register feeds the port; the skid register
  // catches a result produced while the port is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (accept) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (accept) begin
        skid_res <= result;
      end
    end else if (skid_valid) begin
      out_res <= skid_res;
    end else if (accept) begin
      out_res <= result;
    end
  end

  assign send_accepted = out_res.tx.send_accepted;
  assign code_valid    = out_res.rx.code_valid;
  assign received_code = out_res.rx.received_code;
  assign led_lines     = out_res.tx.led_lines;
  assign carrier_run   = out_res.tx.carrier_run;
  assign busy_sending  = out_res.tx.busy_sending;
  assign quiet_level   = out_res.rx.quiet_level;

endmodule

`default_nettype wire
